[sv/tkss_pkg.sv]
// Shared types, codes and key compare function for the typed key set store.
`default_nettype none
package tkss_pkg;

  localparam int TKSS_CAPACITY = 64;

  localparam logic [1:0] ACT_QUERY  = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  localparam logic [1:0] KIND_INT   = 2'd0;
  localparam logic [1:0] KIND_FLOAT = 2'd1;
  localparam logic [1:0] KIND_POINT = 2'd2;
  localparam logic [1:0] KIND_BAD   = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic [31:0] col;
    logic [31:0] row;
  } key_t;

  function automatic logic float_is_nan(input logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

  function automatic logic key_match(input key_t stored, input key_t probe);
    logic eq;
    eq = 1'b0;
    if (stored.kind == probe.kind) begin
      case (probe.kind)
        KIND_INT: begin
          eq = (stored.value == probe.value);
        end
        KIND_FLOAT: begin
          if (float_is_nan(stored.value) || float_is_nan(probe.value)) begin
            eq = 1'b0;
          end else if ((stored.value[30:0] == 31'd0) && (probe.value[30:0] == 31'd0)) begin
            eq = 1'b1;
          end else begin
            eq = (stored.value == probe.value);
          end
        end
        KIND_POINT: begin
          eq = (stored.value == probe.value) && (stored.col == probe.col) &&
               (stored.row == probe.row);
        end
        default: begin
          eq = 1'b0;
        end
      endcase
    end
    return eq;
  endfunction

endpackage
`default_nettype wire

[sv/tkss_cell.sv]
// One storage cell of the key chain: holds a key, compares, shifts down on removal.
`default_nettype none
module tkss_cell import tkss_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cmp_en,
  input  wire logic slot_valid,
  input  wire key_t cmp_key,
  input  wire logic ins_en,
  input  wire key_t ins_key,
  input  wire logic rem_en,
  input  wire key_t nbr_in,
  input  wire logic shift_in,
  output key_t      entry_out,
  output logic      shift_out,
  output logic      hit
);

  key_t entry_r;
  logic match_r;

  assign entry_out = entry_r;
  assign hit       = match_r;
  assign shift_out = shift_in | match_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (cmp_en) begin
      match_r <= slot_valid && key_match(entry_r, cmp_key);
    end
  end

  always_ff @(posedge clk) begin
    if (ins_en) begin
      entry_r <= ins_key;
    end else if (rem_en && shift_out) begin
      entry_r <= nbr_in;
    end
  end

endmodule
`default_nettype wire

[sv/typed_key_set_store_top.sv]
// Top level of the typed key set store: cell chain, count and result register.
// The result beat is registered in ST_EXEC, after the request beat is accepted in ST_IDLE,
// once the output is free. A new request is taken only in ST_IDLE; the cells compare at
// the accept edge, and the update and result are taken in ST_EXEC through the shift chain.
// Reset: synchronous active-low rst_n empties the store; cell contents stay undefined.
`default_nettype none
module typed_key_set_store_top import tkss_pkg::*; #(
  parameter int CAPACITY = TKSS_CAPACITY
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // action[1:0], key_value[33:2], key_x[65:34], key_y[97:66], zero
  input  wire logic [103:0] in_tdata,
  // element_kind[1:0], zero
  input  wire logic [7:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // success[0], was_member[1], entry_count[8:2], zero
  output logic [15:0]       out_tdata
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int EXT_W = (CNT_W > 7) ? CNT_W : 7;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [1:0]         action_r;
  key_t               key_r;
  key_t               key_in;
  logic               out_tvalid_r;
  logic [8:0]         out_data_r;

  key_t               entry_w [0:CAPACITY];
  logic [CAPACITY:0]  shift_w;
  logic [CAPACITY-1:0] hit_w;

  logic in_go, exec_go, found, full, ins_ok, rem_ok, success;
  logic ins_go, rem_go;
  logic [EXT_W-1:0] cnt_ext;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_go      = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, out_data_r};

  always_comb begin
    key_in.kind  = in_tuser[1:0];
    key_in.value = in_tdata[33:2];
    key_in.col   = (in_tuser[1:0] == KIND_POINT) ? in_tdata[65:34] : 32'd0;
    key_in.row   = (in_tuser[1:0] == KIND_POINT) ? in_tdata[97:66] : 32'd0;
  end

  assign entry_w[CAPACITY] = '0;
  assign shift_w[0]        = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    tkss_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmp_en     (in_go),
      .slot_valid (CNT_W'(i) < count_r),
      .cmp_key    (key_in),
      .ins_en     (ins_go && (count_r == CNT_W'(i))),
      .ins_key    (key_r),
      .rem_en     (rem_go),
      .nbr_in     (entry_w[i+1]),
      .shift_in   (shift_w[i]),
      .entry_out  (entry_w[i]),
      .shift_out  (shift_w[i+1]),
      .hit        (hit_w[i])
    );
  end

  assign found   = shift_w[CAPACITY];
  assign full    = (count_r == CNT_W'(CAPACITY));
  assign exec_go = (state_r == ST_EXEC) && (!out_tvalid_r || out_tready);
  assign ins_ok  = (action_r == ACT_INSERT) && !found && !full && (key_r.kind != KIND_BAD);
  assign rem_ok  = (action_r == ACT_REMOVE) && found;
  assign success = ((action_r == ACT_QUERY) && found) || ins_ok || rem_ok;
  assign ins_go  = exec_go && ins_ok;
  assign rem_go  = exec_go && rem_ok;

  always_comb begin
    count_nxt = count_r;
    if (ins_go) begin
      count_nxt = count_r + 1'b1;
    end else if (rem_go) begin
      count_nxt = count_r - 1'b1;
    end
  end

  assign cnt_ext = EXT_W'(count_nxt);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_go) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (exec_go) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      action_r <= in_tdata[1:0];
      key_r    <= key_in;
    end
    if (exec_go) begin
      out_data_r <= {cnt_ext[6:0], found, success};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("stored count above capacity");

  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |-> $onehot0(hit_w))
    else $error("more than one cell matched the key");

  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    rem_go |=> (count_r == CNT_W'($past(count_r) - 1'b1)))
    else $error("remove did not drop the count by one");

endmodule
`default_nettype wire
